// ===== src/ttm_pkg.sv =====
// Shared constants and types for the tap-tempo metronome.
package ttm_pkg;

  // Width of the tick counter, stamps and intervals; they all wrap at this width.
  localparam int unsigned TimeW = 32;

  // Width of the divider operands.
  localparam int unsigned DivW = 16;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  // Ticks in one minute.
  localparam logic [DivW-1:0] MinuteTicks = 16'd60000;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LED_ON   = 2'd1,
    REG_TIMEOUT  = 2'd2,
    REG_START    = 2'd3
  } cfg_reg_e;

  // Register reset values.
  localparam logic [9:0]  DebounceRst = 10'd50;
  localparam logic [15:0] LedOnRst    = 16'd200;
  localparam logic [15:0] TimeoutRst  = 16'd3600;
  localparam logic [15:0] StartBpmRst = 16'd120;

  // Request to the divider: start a division of dividend by divisor.
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  // Divider status: done pulses for one cycle with the quotient valid.
  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/tap_tempo_metronome.sv =====
// Top level of the tap-tempo metronome with a debounced tap button.
//
// Channel  Direction  Handshake                      Contents
// s_axis   in         s_axis_tvalid / s_axis_tready  one millisecond tick, raw button level
// m_axis   out        m_axis_tvalid / m_axis_tready  LED, tempo, tap count, tap flag
// cfg      in         cfg_we_i (no wait)             register index and value
//
// Each tick item runs the serial divider once for the beat period, and once
// more for a new tempo when it completes a fourth tap whose mean interval is
// nonzero and within one minute. A new item is accepted only while the
// sequencer is idle. The result sits in an output register, so the next tick
// is taken while it waits; the sequencer stalls at its last step only while
// that register is still full. Reset (rst_ni low, asynchronous) restores all
// registers to their reset values and the tempo to 120.
module tap_tempo_metronome (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Tick input, bits from low up: button_level (1), then zero fill.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,
  // Result, bits from low up: led_lit (1), tempo_bpm (16), taps_counted (2),
  // tap_seen (1), then zero fill.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [ttm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ttm_pkg::CfgDataW-1:0]    cfg_data_i
);
  import ttm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEB,
    S_MEAN,
    S_TAPDIV,
    S_PER,
    S_PERDIV,
    S_LED,
    S_FIN
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [9:0]  debounce_q;
  logic [15:0] led_on_q;
  logic [15:0] timeout_q;

  // Tick processing state.
  logic [TimeW-1:0] now_q;
  logic             raw_q;
  logic             raw_prev_q;
  logic             stable_q;
  logic [TimeW-1:0] change_stamp_q;
  logic [1:0]       tap_idx_q;
  logic [TimeW-1:0] first_tap_q;
  logic [TimeW-1:0] gap_one_q;
  logic [TimeW-1:0] gap_two_q;
  logic [15:0]      rate_q;
  logic [TimeW-1:0] beat_stamp_q;
  logic             lamp_q;
  logic             tap_q;
  logic [TimeW-1:0] mean_q;
  logic [DivW-1:0]  period_q;

  // Output register.
  logic        out_valid_q;
  logic [23:0] out_data_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  ttm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Debounce: the change stamp moves to now whenever the raw level differs
  // from the previous tick, and the level is taken once it has held for
  // strictly more than the debounce count.
  logic [TimeW-1:0] change_stamp_d;
  logic [TimeW-1:0] since_change;
  logic             level_taken;
  assign change_stamp_d = (raw_q != raw_prev_q) ? now_q : change_stamp_q;
  assign since_change   = now_q - change_stamp_d;
  assign level_taken    = (since_change > TimeW'(debounce_q)) && (raw_q != stable_q);

  // Interval arithmetic for the tap sequence.
  logic [TimeW-1:0] gap_one_d;
  logic [TimeW-1:0] gap_two_d;
  logic [TimeW-1:0] gap_sum;
  assign gap_one_d = now_q - first_tap_q;
  assign gap_two_d = now_q - (gap_one_q + first_tap_q);
  assign gap_sum   = gap_one_q + gap_two_q;

  // A nonzero mean interval within one minute is divided; otherwise the tempo is fixed.
  logic mean_zero;
  logic mean_slow;
  assign mean_zero = (mean_q == '0);
  assign mean_slow = (mean_q > TimeW'(MinuteTicks));

  // LED timing against the last beat.
  logic [TimeW-1:0] since_beat;
  logic             lamp_off;
  assign since_beat = now_q - beat_stamp_q;
  assign lamp_off   = lamp_q && (since_beat >= TimeW'(led_on_q));

  // Measurement timeout, checked after the tap and LED work of the tick.
  logic [TimeW-1:0] since_first;
  logic             timed_out;
  assign since_first = now_q - first_tap_q;
  assign timed_out   = since_first > TimeW'(timeout_q);

  // The single divider serves both the new tempo and the beat period; a zero
  // tempo counts as one beat per minute.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = MinuteTicks;
    div_req.divisor  = mean_q[DivW-1:0];
    unique case (state_q)
      S_MEAN: begin
        div_req.start = !mean_zero && !mean_slow;
      end
      S_PER: begin
        div_req.start   = 1'b1;
        div_req.divisor = (rate_q == '0) ? DivW'(1) : rate_q;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      debounce_q     <= DebounceRst;
      led_on_q       <= LedOnRst;
      timeout_q      <= TimeoutRst;
      now_q          <= '0;
      raw_q          <= 1'b0;
      raw_prev_q     <= 1'b0;
      stable_q       <= 1'b0;
      change_stamp_q <= '0;
      tap_idx_q      <= '0;
      first_tap_q    <= '0;
      gap_one_q      <= '0;
      gap_two_q      <= '0;
      rate_q         <= StartBpmRst;
      beat_stamp_q   <= '0;
      lamp_q         <= 1'b0;
      tap_q          <= 1'b0;
      mean_q         <= '0;
      period_q       <= '0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      // The user must write only while no tick is in flight; the block itself does not enforce it.
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_DEBOUNCE: debounce_q <= cfg_data_i[9:0];
          REG_LED_ON:   led_on_q   <= cfg_data_i;
          REG_TIMEOUT:  timeout_q  <= cfg_data_i;
          REG_START:    rate_q     <= cfg_data_i;
          default:      debounce_q <= debounce_q;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            raw_q   <= s_axis_tdata[0];
            state_q <= S_DEB;
          end
        end

        S_DEB: begin
          change_stamp_q <= change_stamp_d;
          raw_prev_q     <= raw_q;
          tap_q          <= 1'b0;
          state_q        <= S_PER;
          if (level_taken) begin
            stable_q <= raw_q;
            if (!raw_q) begin
              tap_q <= 1'b1;
              unique case (tap_idx_q)
                2'd0: begin
                  first_tap_q <= now_q;
                  tap_idx_q   <= 2'd1;
                end
                2'd1: begin
                  gap_one_q <= gap_one_d;
                  tap_idx_q <= 2'd2;
                end
                2'd2: begin
                  gap_two_q <= gap_two_d;
                  tap_idx_q <= 2'd3;
                end
                default: begin
                  // Fourth tap: take the mean and start a fresh measurement.
                  mean_q      <= {1'b0, gap_sum[TimeW-1:1]};
                  tap_idx_q   <= '0;
                  first_tap_q <= '0;
                  gap_one_q   <= '0;
                  gap_two_q   <= '0;
                  state_q     <= S_MEAN;
                end
              endcase
            end
          end
        end

        S_MEAN: begin
          priority if (mean_zero) begin
            rate_q  <= MinuteTicks;
            state_q <= S_PER;
          end else if (mean_slow) begin
            rate_q  <= 16'd1;
            state_q <= S_PER;
          end else begin
            state_q <= S_TAPDIV;
          end
        end

        S_TAPDIV: begin
          if (div_rsp.done) begin
            rate_q  <= div_rsp.quotient;
            state_q <= S_PER;
          end
        end

        S_PER: begin
          state_q <= S_PERDIV;
        end

        S_PERDIV: begin
          if (div_rsp.done) begin
            period_q <= div_rsp.quotient;
            state_q  <= S_LED;
          end
        end

        S_LED: begin
          // The lamp goes dark after its on time and relights one period
          // after the previous beat, possibly within the same tick.
          if (!(lamp_q && !lamp_off) && (since_beat >= TimeW'(period_q))) begin
            lamp_q       <= 1'b1;
            beat_stamp_q <= now_q;
          end else if (lamp_off) begin
            lamp_q <= 1'b0;
          end
          state_q <= S_FIN;
        end

        S_FIN: begin
          if (out_free) begin
            if (timed_out) begin
              tap_idx_q   <= '0;
              first_tap_q <= '0;
              gap_one_q   <= '0;
              gap_two_q   <= '0;
            end
            out_valid_q <= 1'b1;
            out_data_q  <= {4'd0, tap_q, (timed_out ? 2'd0 : tap_idx_q), rate_q, lamp_q};
            now_q       <= now_q + TimeW'(1);
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== src/ttm_div.sv =====
// Radix-2 restoring divider that yields one quotient bit per cycle.
module ttm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttm_pkg::div_req_t req_i,
  output ttm_pkg::div_rsp_t rsp_o
);
  import ttm_pkg::*;

  logic [DivW-1:0]    rem_q;
  logic [DivW-1:0]    quo_q;
  logic [DivW-1:0]    divisor_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [DivW:0]   rem_sh;
  logic            ge;
  logic [DivW:0]   rem_sub;
  logic [DivW-1:0] rem_d;

  // The remainder always stays below the divisor, so DivW bits hold it.
  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign ge      = rem_sh >= {1'b0, divisor_q};
  assign rem_sub = rem_sh - {1'b0, divisor_q};
  assign rem_d   = ge ? rem_sub[DivW-1:0] : rem_sh[DivW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DivCntW'(DivW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= '0;
      quo_q     <= req_i.dividend;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== tb/sv/tap_tempo_metronome_tb.sv =====
// Self-checking testbench for the tap-tempo metronome: directed taps, then random tap trains.
`timescale 1ns / 1ps

module tap_tempo_metronome_tb;
  import ttm_pkg::*;

  // Cycles the block may still need after its last result before it counts as idle.
  localparam int unsigned SettleCycles = 64;

  // One result item as the block reports it after a tick.
  typedef struct packed {
    logic        led_lit;
    logic [15:0] tempo_bpm;
    logic [1:0]  taps_counted;
    logic        tap_seen;
  } tick_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [23:0]         m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Idle rates in percent of cycles, changed from phase to phase.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Results predicted for accepted ticks, oldest first.
  tick_result_t pending_ticks_q[$];
  int unsigned  err_count;
  int unsigned  ticks_sent;

  // Local copy of the configuration registers.
  logic [9:0]  cfg_debounce;
  logic [15:0] cfg_led_on;
  logic [15:0] cfg_timeout;

  // Local copy of the metronome state.
  logic [31:0] tick_now;
  logic        raw_last;
  logic        level_stable;
  logic [31:0] change_at;
  logic [1:0]  taps_held;
  logic [31:0] first_tap_at;
  logic [31:0] interval_a;
  logic [31:0] interval_b;
  logic [15:0] tempo_now;
  logic [31:0] beat_at;
  logic        led_on;

  tap_tempo_metronome u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Puts the local copy of configuration and state at the values after reset.
  task automatic clear_metronome_model();
    cfg_debounce = DebounceRst;
    cfg_led_on   = LedOnRst;
    cfg_timeout  = TimeoutRst;
    tick_now     = '0;
    raw_last     = 1'b0;
    level_stable = 1'b0;
    change_at    = '0;
    taps_held    = '0;
    first_tap_at = '0;
    interval_a   = '0;
    interval_b   = '0;
    tempo_now    = StartBpmRst;
    beat_at      = '0;
    led_on       = 1'b0;
  endtask

  // Advances the local state by one millisecond tick and returns what the
  // block should report for it. Order within a tick: debounce and taps, then
  // the LED, then the measurement timeout.
  task automatic metronome_tick(input logic level, output tick_result_t res);
    logic [31:0] t;
    logic [31:0] held;
    logic [31:0] mean;
    logic [31:0] rate;
    logic [31:0] period;
    logic [31:0] since_beat;
    logic [31:0] since_first;
    logic        tap;
    t   = tick_now;
    tap = 1'b0;

    if (level != raw_last) begin
      change_at = t;
    end
    held = t - change_at;
    if (held > {22'd0, cfg_debounce} && level != level_stable) begin
      level_stable = level;
      // A debounced fall to low is a tap.
      if (!level) begin
        tap = 1'b1;
        case (taps_held)
          2'd0: begin
            first_tap_at = t;
            taps_held    = 2'd1;
          end
          2'd1: begin
            interval_a = t - first_tap_at;
            taps_held  = 2'd2;
          end
          2'd2: begin
            // The second interval runs from the second tap.
            interval_b = t - (interval_a + first_tap_at);
            taps_held  = 2'd3;
          end
          default: begin
            mean = (interval_a + interval_b) >> 1;
            if (mean == 0) begin
              tempo_now = MinuteTicks;
            end else if (mean > 32'd60000) begin
              tempo_now = 16'd1;
            end else begin
              tempo_now = 16'(32'd60000 / mean);
            end
            taps_held    = '0;
            first_tap_at = '0;
            interval_a   = '0;
            interval_b   = '0;
          end
        endcase
      end
    end
    raw_last = level;

    // A zero tempo counts as one beat per minute for the beat period.
    rate       = (tempo_now == 0) ? 32'd1 : {16'd0, tempo_now};
    period     = 32'd60000 / rate;
    since_beat = t - beat_at;
    if (led_on && since_beat >= {16'd0, cfg_led_on}) begin
      led_on = 1'b0;
    end
    if (!led_on && since_beat >= period) begin
      led_on  = 1'b1;
      beat_at = t;
    end

    // Without a running measurement this clears state that is already clear.
    since_first = t - first_tap_at;
    if (since_first > {16'd0, cfg_timeout}) begin
      taps_held    = '0;
      first_tap_at = '0;
      interval_a   = '0;
      interval_b   = '0;
    end

    tick_now = t + 32'd1;

    res.led_lit      = led_on;
    res.tempo_bpm    = tempo_now;
    res.taps_counted = taps_held;
    res.tap_seen     = tap;
  endtask

  task automatic report_miss(input string what);
    err_count++;
    if (err_count <= 10) begin
      $display("%s", what);
    end
  endtask

  // Offers one tick item, idling first at the current sender rate, and files
  // its predicted result once the block has taken it.
  task automatic send_tick(input logic level);
    tick_result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, level};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    metronome_tick(level, res);
    pending_ticks_q.push_back(res);
    ticks_sent++;
  endtask

  // Holds the button at one level for a number of ticks.
  task automatic send_run(input logic level, input int unsigned count);
    repeat (count) begin
      send_tick(level);
    end
  endtask

  // Stops offering ticks and waits until every predicted result has come
  // and the block has had time to finish any work in flight.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_ticks_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes one register; the block takes it at the rising edge.
  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_DEBOUNCE: cfg_debounce = value[9:0];
      REG_LED_ON:   cfg_led_on   = value;
      REG_TIMEOUT:  cfg_timeout  = value;
      // Writing the start tempo also loads the running tempo at once.
      REG_START: begin
        tempo_now = value;
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_settings(input logic [15:0] deb, input logic [15:0] led,
                                input logic [15:0] tmo, input logic [15:0] bpm);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LED_ON, led);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_START, bpm);
  endtask

  // The receiver stalls at its own rate; results are checked in order at the
  // rising edge on which they are taken.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    tick_result_t want;
    logic [23:0]  got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_ticks_q.size() == 0) begin
        report_miss($sformatf("unexpected result item %h", got));
      end else begin
        want = pending_ticks_q.pop_front();
        if (got[0] !== want.led_lit || got[16:1] !== want.tempo_bpm ||
            got[18:17] !== want.taps_counted || got[19] !== want.tap_seen) begin
          report_miss($sformatf(
              "result mismatch: led %b/%b tempo %0d/%0d taps %0d/%0d tap %b/%b (exp/act)",
              want.led_lit, got[0], want.tempo_bpm, got[16:1],
              want.taps_counted, got[18:17], want.tap_seen, got[19]));
        end
      end
    end
  end

  // Right after reset the tempo is the default one and the button rests low.
  task automatic test_reset_tempo();
    send_run(1'b0, 2);
  endtask

  // A start tempo of zero loads a zero tempo, whose beat period is a minute.
  task automatic test_zero_tempo();
    settle();
    write_reg(REG_START, 16'd0);
    write_reg(REG_LED_ON, 16'd1);
    send_run(1'b0, 2);
  endtask

  // Four clean taps at a debounce of one tick give a tempo from the mean
  // interval. The debounce value carries upper bits that the block drops.
  task automatic test_four_tap_measure();
    settle();
    write_settings(16'hFC01, 16'd60000, 16'd60000, 16'd60000);
    repeat (4) begin
      send_run(1'b1, 3);
      send_run(1'b0, 3);
    end
  endtask

  // Chooses one register setting for a random segment; some segments push
  // the LED, timeout and tempo registers to very small or very large values.
  task automatic pick_settings(input int unsigned phase, input int unsigned seg);
    logic [15:0] deb;
    logic [15:0] led;
    logic [15:0] tmo;
    logic [15:0] bpm;
    case (seg)
      0: begin
        deb = 16'($urandom_range(1, 4));
        led = 16'($urandom_range(1, 20));
        tmo = 16'($urandom_range(30, 300));
        bpm = 16'($urandom_range(600, 6000));
      end
      1: begin
        // Random upper bits in the debounce write are masked away.
        deb = {6'($urandom), 10'($urandom_range(1, 3))};
        led = 16'd1;
        tmo = 16'd60000;
        bpm = 16'($urandom_range(0, 1));
      end
      2: begin
        deb = (phase == 0) ? 16'd1000 : 16'($urandom_range(1, 6));
        led = 16'd60000;
        tmo = 16'd1;
        bpm = 16'd60000;
      end
      default: begin
        deb = 16'($urandom_range(1, 8));
        led = 16'($urandom_range(1, 100));
        tmo = 16'($urandom_range(1, 60000));
        bpm = 16'($urandom_range(1, 60000));
      end
    endcase
    write_settings(deb, led, tmo, bpm);
  endtask

  // Mostly well-formed presses with random lengths, some with a bounce,
  // mixed with noise and long holds that let a measurement time out.
  task automatic run_tap_segment(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    target = ticks_sent + count;
    while (ticks_sent < target) begin
      pick = $urandom_range(99);
      if (cfg_debounce <= 8 && pick < 80) begin
        send_run(1'b1, cfg_debounce + 2 + $urandom_range(0, 3));
        if (pick < 10) begin
          send_run(1'b0, 1);
          send_run(1'b1, cfg_debounce + 2);
        end
        send_run(1'b0, cfg_debounce + 2 + $urandom_range(0, 3));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
      end else begin
        send_run(1'($urandom_range(1)), $urandom_range(10, 60));
      end
    end
  endtask

  // One random phase: four segments, each under its own register setting.
  task automatic test_random_taps(input int unsigned phase);
    for (int unsigned seg = 0; seg < 4; seg++) begin
      settle();
      pick_settings(phase, seg);
      run_tap_segment(120);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_DEBOUNCE;
    cfg_data_i    = '0;
    send_idle_pct = 36;
    recv_idle_pct = 67;
    err_count     = 0;
    ticks_sent    = 0;
    clear_metronome_model();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_tempo();
    test_zero_tempo();
    test_four_tap_measure();

    test_random_taps(0);
    send_idle_pct = 67;
    recv_idle_pct = 36;
    test_random_taps(1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_taps(2);

    settle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit, many times the slowest correct run.
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
